// File: rtl/core/mssp_pkg.sv
package mssp_pkg;

  localparam int STACK_COUNT = 10;
  localparam int POOL_NODES  = 64;
  localparam int VALUE_BITS  = 32;

  localparam int STK_W  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam int ADDR_W = $clog2(POOL_NODES);
  localparam int NODE_W = $clog2(POOL_NODES + 1);

  localparam logic [NODE_W-1:0] NODE_NULL = NODE_W'(POOL_NODES);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [3:0]         stack_index;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic               was_empty;
    logic               was_full;
  } out_t;

  typedef struct packed {
    logic                  val_we;
    logic                  lnk_we;
    logic [ADDR_W-1:0]     addr;
    logic [VALUE_BITS-1:0] val;
    logic [NODE_W-1:0]     lnk;
  } node_wr_t;

  typedef struct packed {
    logic              we;
    logic [STK_W-1:0]  addr;
    logic [NODE_W-1:0] ptr;
  } top_wr_t;

  function automatic logic signed [31:0] widen_value(input logic [VALUE_BITS-1:0] v);
    logic signed [VALUE_BITS-1:0] sv;
    sv = $signed(v);
    return 32'(sv);
  endfunction

endpackage

// File: rtl/core/multi_stack_shared_pool.sv
// channel  ports                      dir  transfer
// input    start, busy, in_data       in   start && !busy at rising edge
// result   out_valid, out_data        out  out_valid high for one cycle
//
// Push: top pointer and free-list link read, then write back.
// Pop: top pointer read, node read, then write back; the node read is addressed
// by the top pointer that the first read returns.
// Pop of an empty stack ends after the top pointer read. Out-of-range stack index: all-zero result.
// Synchronous reset empties all stacks and the free list; the receiver cannot stall.
module multi_stack_shared_pool (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mssp_pkg::in_t  in_data,
  output logic           out_valid,
  output mssp_pkg::out_t out_data
);
  import mssp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PUSH  = 4'b0010,
    ST_POP_T = 4'b0100,
    ST_POP_N = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  in_t               item_r, item_nxt;
  logic [NODE_W-1:0] free_head_r, free_head_nxt;
  logic [NODE_W-1:0] fresh_cnt_r, fresh_cnt_nxt;
  logic [NODE_W-1:0] pop_node_r, pop_node_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic [STK_W-1:0]      top_rd_addr;
  logic [NODE_W-1:0]     top_rd_ptr;
  top_wr_t               top_wr;
  logic [ADDR_W-1:0]     node_rd_addr;
  logic [VALUE_BITS-1:0] node_rd_val;
  logic [NODE_W-1:0]     node_rd_lnk;
  node_wr_t              node_wr;
  logic                  accept;
  logic                  in_range;

  mssp_top_mem u_top_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (top_rd_addr),
    .rd_ptr  (top_rd_ptr),
    .wr      (top_wr)
  );

  mssp_node_mem u_node_mem (
    .clk     (clk),
    .rd_addr (node_rd_addr),
    .rd_val  (node_rd_val),
    .rd_lnk  (node_rd_lnk),
    .wr      (node_wr)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = int'(in_data.stack_index) < STACK_COUNT;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    free_head_nxt = free_head_r;
    fresh_cnt_nxt = fresh_cnt_r;
    pop_node_nxt  = pop_node_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    top_rd_addr   = STK_W'(item_r.stack_index);
    node_rd_addr  = free_head_r[ADDR_W-1:0];
    top_wr        = '0;
    top_wr.addr   = STK_W'(item_r.stack_index);
    node_wr       = '0;

    case (state_r)
      ST_IDLE: begin
        top_rd_addr = STK_W'(in_data.stack_index);
        if (accept) begin
          item_nxt = in_data;
          if (!in_range) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end else if (in_data.mode == MODE_POP) begin
            state_nxt = ST_POP_T;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        node_wr.val   = VALUE_BITS'(item_r.push_value);
        node_wr.lnk   = top_rd_ptr;
        if (free_head_r < NODE_NULL) begin
          node_wr.val_we = 1'b1;
          node_wr.lnk_we = 1'b1;
          node_wr.addr   = free_head_r[ADDR_W-1:0];
          top_wr.we      = 1'b1;
          top_wr.ptr     = free_head_r;
          free_head_nxt  = node_rd_lnk;
        end else if (fresh_cnt_r < NODE_NULL) begin
          node_wr.val_we = 1'b1;
          node_wr.lnk_we = 1'b1;
          node_wr.addr   = fresh_cnt_r[ADDR_W-1:0];
          top_wr.we      = 1'b1;
          top_wr.ptr     = fresh_cnt_r;
          fresh_cnt_nxt  = fresh_cnt_r + 1'b1;
        end else begin
          out_nxt.was_full = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_POP_T: begin
        node_rd_addr = top_rd_ptr[ADDR_W-1:0];
        pop_node_nxt = top_rd_ptr;
        if (top_rd_ptr < NODE_NULL) begin
          state_nxt = ST_POP_N;
        end else begin
          out_valid_nxt     = 1'b1;
          out_nxt           = '0;
          out_nxt.was_empty = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_POP_N: begin
        top_wr.we            = 1'b1;
        top_wr.ptr           = node_rd_lnk;
        node_wr.lnk_we       = 1'b1;
        node_wr.addr         = pop_node_r[ADDR_W-1:0];
        node_wr.lnk          = free_head_r;
        free_head_nxt        = pop_node_r;
        out_valid_nxt        = 1'b1;
        out_nxt              = '0;
        out_nxt.popped_value = widen_value(node_rd_val);
        state_nxt            = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_head_r <= NODE_NULL;
      fresh_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fresh_cnt_r <= fresh_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pop_node_r <= pop_node_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/mssp_node_mem.sv
module mssp_node_mem (
  input  logic                            clk,
  input  logic [mssp_pkg::ADDR_W-1:0]     rd_addr,
  output logic [mssp_pkg::VALUE_BITS-1:0] rd_val,
  output logic [mssp_pkg::NODE_W-1:0]     rd_lnk,
  input  mssp_pkg::node_wr_t              wr
);
  import mssp_pkg::*;

  logic [VALUE_BITS-1:0] val_mem [POOL_NODES];
  logic [NODE_W-1:0]     lnk_mem [POOL_NODES];

  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[wr.addr] <= wr.val;
    end
    if (wr.lnk_we) begin
      lnk_mem[wr.addr] <= wr.lnk;
    end
    rd_val <= val_mem[rd_addr];
    rd_lnk <= lnk_mem[rd_addr];
  end

endmodule

// File: rtl/core/mssp_top_mem.sv
module mssp_top_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mssp_pkg::STK_W-1:0]   rd_addr,
  output logic [mssp_pkg::NODE_W-1:0]  rd_ptr,
  input  mssp_pkg::top_wr_t            wr
);
  import mssp_pkg::*;

  logic [NODE_W-1:0]      top_mem [STACK_COUNT];
  logic [STACK_COUNT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      top_mem[wr.addr] <= wr.ptr;
    end
    if ((int'(rd_addr) < STACK_COUNT) && vld_r[rd_addr]) begin
      rd_ptr <= top_mem[rd_addr];
    end else begin
      rd_ptr <= NODE_NULL;
    end
  end

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mssp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_OPS  = 1800;
  localparam int SHOW_ERRORS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  multi_stack_shared_pool uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow copy of the pool
  logic [NODE_W-1:0]     top_of    [STACK_COUNT];
  logic [VALUE_BITS-1:0] node_val  [POOL_NODES];
  logic [NODE_W-1:0]     node_next [POOL_NODES];
  logic [NODE_W-1:0]     free_head;
  logic [NODE_W-1:0]     fresh_cnt;

  in_t  stack_ops [$];
  out_t stack_replies [$];
  out_t want;
  int   total_ops;
  int   sent_ops;
  int   errors;
  int   idle_pct;

  function automatic void clear_pool();
    for (int k = 0; k < STACK_COUNT; k++) top_of[k] = NODE_NULL;
    free_head = NODE_NULL;
    fresh_cnt = '0;
  endfunction

  function automatic out_t apply_stack_op(in_t op);
    out_t r;
    logic [NODE_W-1:0] n;
    logic signed [VALUE_BITS-1:0] sv;
    r = '0;
    if (op.stack_index < STACK_COUNT) begin
      if (op.mode == MODE_PUSH) begin
        if (free_head != NODE_NULL) begin
          n = free_head;
          free_head = node_next[free_head];
        end else if (fresh_cnt < POOL_NODES) begin
          n = fresh_cnt;
          fresh_cnt = fresh_cnt + 1'b1;
        end else begin
          n = NODE_NULL;
        end
        if (n == NODE_NULL) begin
          r.was_full = 1'b1;
        end else begin
          node_val[n] = VALUE_BITS'($unsigned(op.push_value));
          node_next[n] = top_of[op.stack_index];
          top_of[op.stack_index] = n;
        end
      end else begin
        n = top_of[op.stack_index];
        if (n != NODE_NULL) begin
          sv = node_val[n];
          r.popped_value = 32'(sv);
          top_of[op.stack_index] = node_next[n];
          node_next[n] = free_head;
          free_head = n;
        end else begin
          r.was_empty = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic void add_op(logic mode, int idx, logic [31:0] value);
    in_t op;
    op.mode = mode;
    op.stack_index = 4'(idx);
    op.push_value = value;
    stack_ops.push_back(op);
  endfunction

  task automatic flag_error(string what, out_t exp_r, out_t got_r);
    errors++;
    if (errors <= SHOW_ERRORS)
      $display("tb: %s expected value=%h empty=%b full=%b got value=%h empty=%b full=%b",
               what, exp_r.popped_value, exp_r.was_empty, exp_r.was_full,
               got_r.popped_value, got_r.was_empty, got_r.was_full);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        stack_replies.push_back(apply_stack_op(in_data));
        stack_ops.delete(0);
        sent_ops++;
      end
      if (sent_ops < total_ops / 3) idle_pct = 27;
      else if (sent_ops < 2 * total_ops / 3) idle_pct = 55;
      else idle_pct = 0;
      if (start && busy) begin
        start <= 1'b1;
      end else if (stack_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_data <= stack_ops[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (stack_replies.size() == 0) begin
        flag_error("unexpected transaction", '0, out_data);
      end else begin
        want = stack_replies.pop_front();
        if (out_data.popped_value !== want.popped_value ||
            out_data.was_empty !== want.was_empty ||
            out_data.was_full !== want.was_full)
          flag_error("mismatch", want, out_data);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int counted;
    int seg_len;
    int push_pct;
    int span;
    bit fill_phase;
    in_t op;

    errors = 0;
    sent_ops = 0;
    clear_pool();

    // directed: empty pops, value extremes, ignored indexes, free-list reuse
    add_op(MODE_POP, 0, 32'h0);
    add_op(MODE_PUSH, 0, 32'h7FFF_FFFF);
    add_op(MODE_PUSH, 0, 32'h8000_0000);
    add_op(MODE_PUSH, 9, 32'h0000_0000);
    add_op(MODE_PUSH, 9, 32'hFFFF_FFFF);
    add_op(MODE_PUSH, 15, 32'h5A5A_5A5A);
    add_op(MODE_POP, 10, 32'hA5A5_A5A5);
    add_op(MODE_POP, 12, 32'h0);
    add_op(MODE_POP, 0, 32'h0);
    add_op(MODE_POP, 0, 32'h0);
    add_op(MODE_POP, 0, 32'h0);
    add_op(MODE_PUSH, 3, 32'h0000_0001);
    add_op(MODE_PUSH, 5, 32'hDEAD_BEEF);
    add_op(MODE_POP, 9, 32'h0);
    add_op(MODE_POP, 9, 32'h0);
    add_op(MODE_POP, 9, 32'h0);
    add_op(MODE_POP, 3, 32'h0);
    add_op(MODE_PUSH, 3, 32'h1234_5678);
    add_op(MODE_POP, 5, 32'h0);
    add_op(MODE_POP, 3, 32'h0);
    add_op(MODE_POP, 3, 32'h0);

    // random: alternating fill and drain runs so the pool hits both full and empty
    counted = 0;
    fill_phase = 1'b1;
    while (counted < RANDOM_OPS) begin
      seg_len = $urandom_range(160, 80);
      push_pct = fill_phase ? 90 : 20;
      span = $urandom_range(STACK_COUNT - 1, 0);
      repeat (seg_len) begin
        op.mode = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
        if ($urandom_range(99) < 5)
          op.stack_index = 4'($urandom_range(15, STACK_COUNT));
        else
          op.stack_index = 4'($urandom_range(span, 0));
        op.push_value = $urandom;
        stack_ops.push_back(op);
        if (op.stack_index < STACK_COUNT) counted++;
      end
      fill_phase = ~fill_phase;
    end
    total_ops = stack_ops.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (stack_ops.size() == 0 && stack_replies.size() == 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
